// ===== hw/rtl/euler_trs_matrix_core_macros.svh =====
// Assertion helpers for the transform matrix core
`ifndef EULER_TRS_MATRIX_CORE_MACROS_SVH
`define EULER_TRS_MATRIX_CORE_MACROS_SVH

// implication checked on every clock outside reset
`define ETM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> cons) \
        else $error(msg);

// invariant checked on every clock outside reset
`define ETM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

`endif

// ===== hw/rtl/etm_pkg.sv =====
package etm_pkg;

    localparam int SinA    = 102944;
    localparam int SinB    = 42047;
    localparam int SinC    = 4639;
    localparam int Quarter = 16384;

    localparam int RcpSteps = 7;
    localparam int RcpBits  = 4;
    localparam int RcpWidth = RcpSteps * RcpBits;

    // sine 4 + rotation 3 + entry 3
    localparam int EtmLat = 10;

    typedef logic signed [15:0] t_q15;
    typedef logic signed [31:0] t_q30;

    // round half away from zero of v / 2^15
    function automatic t_q30 rnd15(input logic signed [47:0] v);
        logic [47:0] mag;
        logic [47:0] r;
        t_q30        rs;
        mag = v[47] ? 48'(-v) : 48'(v);
        r   = (mag + 48'd16384) >> 15;
        rs  = signed'(r[31:0]);
        return v[47] ? -rs : rs;
    endfunction

endpackage

// ===== hw/rtl/etm_sin.sv =====
module etm_sin import etm_pkg::*; (
    input  logic        i_clk,
    input  logic [15:0] i_ang,
    output t_q15        o_sin
);

    logic signed [17:0] s18;
    logic signed [17:0] z18;
    logic [14:0]        m0;
    logic [28:0]        p1;
    logic [26:0]        p2;
    logic [12:0]        u2;
    logic [29:0]        p3;
    logic [15:0]        u3;
    logic [30:0]        p4;
    logic [15:0]        u4;
    logic [14:0]        mag;

    logic [14:0] r_m1, r_q1, r_m2, r_q2, r_m3;
    logic        r_neg1, r_neg2, r_neg3;
    logic [15:0] r_t1;
    logic [16:0] r_t2;
    t_q15        r_sin;

    always_comb begin
        s18 = {{2{i_ang[15]}}, i_ang};
        if (s18 > 18'sd16384) begin
            z18 = 18'sd32768 - s18;
        end else if (s18 < -18'sd16384) begin
            z18 = -18'sd32768 - s18;
        end else begin
            z18 = s18;
        end
        m0 = z18[17] ? 15'(-z18) : 15'(z18);
        p1 = 29'(m0) * 29'(m0);
        p2 = 27'(SinC) * 27'(r_q1);
        u2 = 13'((p2 + 27'd8192) >> 14);
        p3 = 30'(r_t1) * 30'(r_q2);
        u3 = 16'((p3 + 30'd8192) >> 14);
        p4 = 31'(r_t2) * 31'(r_m3);
        u4 = 16'((p4 + 31'd16384) >> 15);
        mag = (u4 > 16'd32767) ? 15'h7fff : u4[14:0];
    end

    always_ff @(posedge i_clk) begin
        r_m1   <= m0;
        r_q1   <= 15'((p1 + 29'd8192) >> 14);
        r_neg1 <= z18[17];
        r_t1   <= 16'(SinB) - 16'(u2);
        r_q2   <= r_q1;
        r_m2   <= r_m1;
        r_neg2 <= r_neg1;
        r_t2   <= 17'(SinA) - 17'(u3);
        r_m3   <= r_m2;
        r_neg3 <= r_neg2;
        r_sin  <= r_neg3 ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    end

    assign o_sin = r_sin;

endmodule

// ===== hw/rtl/etm_rcp.sv =====
module etm_rcp import etm_pkg::*; (
    input  logic        i_clk,
    input  t_q15        i_scale,
    output logic [24:0] o_quot,
    output logic        o_neg,
    output logic        o_zero,
    output t_q15        o_scale
);

    logic [15:0]         m0;
    logic [RcpWidth-1:0] num0;

    logic [15:0]         x_rem [RcpSteps];
    logic [RcpWidth-1:0] x_acc [RcpSteps];
    logic [15:0]         x_m   [RcpSteps];
    logic [15:0]         n_rem [RcpSteps];
    logic [RcpWidth-1:0] n_acc [RcpSteps];

    logic [15:0]         r_rem [RcpSteps];
    logic [RcpWidth-1:0] r_acc [RcpSteps];
    logic [15:0]         r_m   [RcpSteps];
    logic                r_neg [RcpSteps];
    logic                r_zero[RcpSteps];
    t_q15                r_k   [RcpSteps];

    always_comb begin
        m0   = i_scale[15] ? 16'(-32'(i_scale)) : 16'(i_scale);
        num0 = RcpWidth'(25'h100_0000 + 25'(m0 >> 1));
        x_rem[0] = '0;
        x_acc[0] = num0;
        x_m[0]   = m0;
        for (int g = 1; g < RcpSteps; g++) begin
            x_rem[g] = r_rem[g-1];
            x_acc[g] = r_acc[g-1];
            x_m[g]   = r_m[g-1];
        end
    end

    // restoring division, four quotient bits per stage
    always_comb begin
        logic [16:0]         wide;
        logic [15:0]         rem;
        logic [RcpWidth-1:0] acc;
        for (int g = 0; g < RcpSteps; g++) begin
            rem = x_rem[g];
            acc = x_acc[g];
            for (int b = 0; b < RcpBits; b++) begin
                wide = {rem, acc[RcpWidth-1]};
                acc  = {acc[RcpWidth-2:0], 1'b0};
                if (wide >= {1'b0, x_m[g]}) begin
                    wide   = wide - {1'b0, x_m[g]};
                    acc[0] = 1'b1;
                end
                rem = wide[15:0];
            end
            n_rem[g] = rem;
            n_acc[g] = acc;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < RcpSteps; g++) begin
            r_rem[g] <= n_rem[g];
            r_acc[g] <= n_acc[g];
            r_m[g]   <= x_m[g];
        end
        r_neg[0]  <= i_scale[15];
        r_zero[0] <= (i_scale == '0);
        r_k[0]    <= i_scale;
        for (int g = 1; g < RcpSteps; g++) begin
            r_neg[g]  <= r_neg[g-1];
            r_zero[g] <= r_zero[g-1];
            r_k[g]    <= r_k[g-1];
        end
    end

    assign o_quot  = r_acc[RcpSteps-1][24:0];
    assign o_neg   = r_neg[RcpSteps-1];
    assign o_zero  = r_zero[RcpSteps-1];
    assign o_scale = r_k[RcpSteps-1];

endmodule

// ===== hw/rtl/etm_rot.sv =====
module etm_rot import etm_pkg::*; (
    input  logic i_clk,
    input  t_q15 i_c1,
    input  t_q15 i_s1,
    input  t_q15 i_c2,
    input  t_q15 i_s2,
    input  t_q15 i_c3,
    input  t_q15 i_s3,
    output t_q30 o_rot [9]
);

    t_q30 r_c1c3, r_s1s2, r_c2s3, r_c1s2, r_c3s1, r_c1s3, r_c2c3, r_s1s3, r_c2s1, r_c1c2;
    t_q15 r_s2a, r_s3a, r_c3a;

    t_q30 r_t0, r_t2, r_t3, r_t5;
    t_q30 r_c1c3b, r_c2s3b, r_c3s1b, r_c1s3b, r_c2c3b, r_s1s3b, r_c2s1b, r_c1c2b;
    t_q15 r_s2b;

    t_q30 r_rot [9];

    always_ff @(posedge i_clk) begin
        r_c1c3 <= 32'(i_c1) * 32'(i_c3);
        r_s1s2 <= 32'(i_s1) * 32'(i_s2);
        r_c2s3 <= 32'(i_c2) * 32'(i_s3);
        r_c1s2 <= 32'(i_c1) * 32'(i_s2);
        r_c3s1 <= 32'(i_c3) * 32'(i_s1);
        r_c1s3 <= 32'(i_c1) * 32'(i_s3);
        r_c2c3 <= 32'(i_c2) * 32'(i_c3);
        r_s1s3 <= 32'(i_s1) * 32'(i_s3);
        r_c2s1 <= 32'(i_c2) * 32'(i_s1);
        r_c1c2 <= 32'(i_c1) * 32'(i_c2);
        r_s2a  <= i_s2;
        r_s3a  <= i_s3;
        r_c3a  <= i_c3;

        r_t0 <= rnd15(48'(r_s1s2) * 48'(r_s3a));
        r_t2 <= rnd15(48'(r_c1s2) * 48'(r_s3a));
        r_t3 <= rnd15(48'(r_s1s2) * 48'(r_c3a));
        r_t5 <= rnd15(48'(r_c1s2) * 48'(r_c3a));
        r_c1c3b <= r_c1c3;
        r_c2s3b <= r_c2s3;
        r_c3s1b <= r_c3s1;
        r_c1s3b <= r_c1s3;
        r_c2c3b <= r_c2c3;
        r_s1s3b <= r_s1s3;
        r_c2s1b <= r_c2s1;
        r_c1c2b <= r_c1c2;
        r_s2b   <= r_s2a;

        r_rot[0] <= r_c1c3b + r_t0;
        r_rot[1] <= r_c2s3b;
        r_rot[2] <= r_t2 - r_c3s1b;
        r_rot[3] <= r_t3 - r_c1s3b;
        r_rot[4] <= r_c2c3b;
        r_rot[5] <= r_t5 + r_s1s3b;
        r_rot[6] <= r_c2s1b;
        r_rot[7] <= -(32'(r_s2b) <<< 15);
        r_rot[8] <= r_c1c2b;
    end

    assign o_rot = r_rot;

endmodule

// ===== hw/rtl/etm_ent.sv =====
module etm_ent import etm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_normal,
    input  t_q30        i_rot,
    input  t_q15        i_scale,
    input  logic [24:0] i_quot,
    input  logic        i_neg,
    input  logic        i_zero,
    output t_q30        o_ent
);

    logic signed [31:0] opnd;
    logic [63:0]        pabs;
    logic [63:0]        psum;
    logic [33:0]        mag;
    t_q30               sat;

    logic signed [63:0] r_p;
    logic               r_flip, r_norm;
    logic [33:0]        r_mag;
    logic               r_rneg;
    t_q30               r_ent;

    always_comb begin
        if (i_normal) begin
            opnd = i_zero ? 32'sh7fff_ffff : signed'({7'b0, i_quot});
        end else begin
            opnd = 32'(i_scale);
        end
        pabs = r_p[63] ? 64'(-r_p) : 64'(r_p);
        psum = pabs + (r_norm ? 64'h2000_0000 : 64'h20_0000);
        mag  = r_norm ? 34'(psum >> 30) : 34'(psum >> 22);
        if (!r_rneg) begin
            sat = (r_mag > 34'h0_7fff_ffff) ? 32'sh7fff_ffff : signed'(r_mag[31:0]);
        end else begin
            sat = (r_mag >= 34'h0_8000_0000) ? 32'sh8000_0000 : -signed'(r_mag[31:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= 64'(opnd) * 64'(i_rot);
        r_flip <= i_normal & i_neg;
        r_norm <= i_normal;
        r_mag  <= mag;
        r_rneg <= r_p[63] ^ r_flip;
        r_ent  <= sat;
    end

    assign o_ent = r_ent;

endmodule

// ===== hw/rtl/euler_trs_matrix_core.sv =====
// Transform matrix core: builds the top three rows of T * Ry * Rx * Rz * S from
// binary angles, Q8.8 scales and Q8.8 translations, all entries Q16.16. Fully
// pipelined: one request is taken every clock (busy is always low) and its result
// appears on o_valid after passing the sine polynomial (4 stages), the rotation
// products (3 stages) and the scaling multiply, round and saturate (3 stages);
// the reciprocal of each scale for normal-matrix requests runs beside the first
// two as a 7-stage divider.
// Results are held for one cycle only and cannot be stalled by the receiver.
module euler_trs_matrix_core import etm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_req_type,
    input  t_q15        i_angle_x,
    input  t_q15        i_angle_y,
    input  t_q15        i_angle_z,
    input  t_q15        i_scale_x,
    input  t_q15        i_scale_y,
    input  t_q15        i_scale_z,
    input  t_q15        i_trans_x,
    input  t_q15        i_trans_y,
    input  t_q15        i_trans_z,
    output logic        o_valid,
    output t_q30        o_col0_x,
    output t_q30        o_col0_y,
    output t_q30        o_col0_z,
    output t_q30        o_col1_x,
    output t_q30        o_col1_y,
    output t_q30        o_col1_z,
    output t_q30        o_col2_x,
    output t_q30        o_col2_y,
    output t_q30        o_col2_z,
    output t_q30        o_col3_x,
    output t_q30        o_col3_y,
    output t_q30        o_col3_z
);

    typedef struct packed {
        logic vld;
        logic normal;
        t_q15 tx;
        t_q15 ty;
        t_q15 tz;
    } t_line;

    t_line r_line [EtmLat];

    t_q15        c1, s1, c2, s2, c3, s3;
    t_q30        rot [9];
    logic [24:0] quot [3];
    logic        rneg [3];
    logic        rzero[3];
    t_q15        rsc  [3];
    t_q15        scl  [3];
    t_q30        ent  [9];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < EtmLat; j++) begin
                r_line[j].vld <= 1'b0;
            end
        end else begin
            r_line[0] <= '{vld: start, normal: i_req_type,
                           tx: i_trans_x, ty: i_trans_y, tz: i_trans_z};
            for (int j = 1; j < EtmLat; j++) begin
                r_line[j] <= r_line[j-1];
            end
        end
    end

    etm_sin u_s1 (.i_clk, .i_ang(i_angle_y), .o_sin(s1));
    etm_sin u_c1 (.i_clk, .i_ang(16'(i_angle_y) + 16'd16384), .o_sin(c1));
    etm_sin u_s2 (.i_clk, .i_ang(i_angle_x), .o_sin(s2));
    etm_sin u_c2 (.i_clk, .i_ang(16'(i_angle_x) + 16'd16384), .o_sin(c2));
    etm_sin u_s3 (.i_clk, .i_ang(i_angle_z), .o_sin(s3));
    etm_sin u_c3 (.i_clk, .i_ang(16'(i_angle_z) + 16'd16384), .o_sin(c3));

    etm_rot u_rot (
        .i_clk,
        .i_c1(c1), .i_s1(s1), .i_c2(c2), .i_s2(s2), .i_c3(c3), .i_s3(s3),
        .o_rot(rot)
    );

    assign scl[0] = i_scale_x;
    assign scl[1] = i_scale_y;
    assign scl[2] = i_scale_z;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        etm_rcp u_rcp (
            .i_clk,
            .i_scale(scl[a]),
            .o_quot (quot[a]),
            .o_neg  (rneg[a]),
            .o_zero (rzero[a]),
            .o_scale(rsc[a])
        );
        for (genvar e = 0; e < 3; e++) begin : g_ent
            etm_ent u_ent (
                .i_clk,
                .i_normal(r_line[RcpSteps-1].normal),
                .i_rot   (rot[a*3+e]),
                .i_scale (rsc[a]),
                .i_quot  (quot[a]),
                .i_neg   (rneg[a]),
                .i_zero  (rzero[a]),
                .o_ent   (ent[a*3+e])
            );
        end
    end

    assign o_valid  = r_line[EtmLat-1].vld;
    assign o_col0_x = ent[0];
    assign o_col0_y = ent[1];
    assign o_col0_z = ent[2];
    assign o_col1_x = ent[3];
    assign o_col1_y = ent[4];
    assign o_col1_z = ent[5];
    assign o_col2_x = ent[6];
    assign o_col2_y = ent[7];
    assign o_col2_z = ent[8];
    assign o_col3_x = r_line[EtmLat-1].normal ? '0 : 32'(r_line[EtmLat-1].tx) <<< 8;
    assign o_col3_y = r_line[EtmLat-1].normal ? '0 : 32'(r_line[EtmLat-1].ty) <<< 8;
    assign o_col3_z = r_line[EtmLat-1].normal ? '0 : 32'(r_line[EtmLat-1].tz) <<< 8;

endmodule

// ===== hw/rtl/etm_chk.sv =====
`include "euler_trs_matrix_core_macros.svh"

module etm_chk import etm_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        i_req_type,
    input logic        o_valid,
    input logic [31:0] o_col3_x,
    input logic [31:0] o_col3_y,
    input logic [31:0] o_col3_z
);

    `ETM_ASSERT_ALWAYS(a_never_busy, busy == 1'b0, "busy raised on a free-running pipeline")
    `ETM_ASSERT_IMP(a_req_to_result, start && !busy, ##EtmLat o_valid, "request produced no result")
    `ETM_ASSERT_IMP(a_no_spurious, !start, ##EtmLat !o_valid, "result without a request")
    `ETM_ASSERT_IMP(a_normal_zero_t, start && !busy && i_req_type, ##EtmLat (o_col3_x == 32'd0 && o_col3_y == 32'd0 && o_col3_z == 32'd0), "normal matrix has nonzero translation")

endmodule

bind euler_trs_matrix_core etm_chk u_etm_chk (.*);
